// ===== rtl/cle_pkg.sv =====
package cle_pkg;

    localparam int LINE_CAPACITY = 128;
    localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

    localparam logic [7:0] KEY_BS     = 8'h08;
    localparam logic [7:0] KEY_LF     = 8'h0A;
    localparam logic [7:0] KEY_CR     = 8'h0D;
    localparam logic [7:0] KEY_ESC    = 8'h1B;
    localparam logic [7:0] KEY_SP     = 8'h20;
    localparam logic [7:0] KEY_CARET  = 8'h5E;
    localparam logic [7:0] KEY_BSLASH = 8'h5C;
    localparam logic [7:0] CARET_OFS  = 8'h40;

    localparam logic FUNC_KEY  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    typedef logic [2:0] t_op;
    localparam t_op OP_READ = 3'd0;
    localparam t_op OP_ESC  = 3'd1;
    localparam t_op OP_CR   = 3'd2;
    localparam t_op OP_BS   = 3'd3;
    localparam t_op OP_KEY  = 3'd4;

    typedef logic [2:0] t_cnt;

endpackage

// ===== rtl/console_line_editor.sv =====
// Channel | Dir | tdata (low bit up)                 | tuser          | tlast
// s       | in  | key_byte[7:0], read_index[14:8]    | func           | -
// m       | out | out_byte[7:0], line_length[15:8]   | kind[1:0]      | last
//
// An item is taken at a clock edge; its store update and store read happen at that edge.
// Results leave one per cycle unless the output stalls; an item gives 0 to 6 results,
// set by its kind and the line state (backspace at line start gives none).
// The next item is taken in the cycle the previous one hands over its final result.
// Reset clears the position and the per-entry valid flags; no clearing pass is needed.
// Output stalls hold the result register and back-pressure the input.
module console_line_editor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // key_byte[7:0], read_index[14:8], zero[15]
    input  logic        i_s_tuser,   // func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // out_byte[7:0], line_length[15:8]
    output logic [1:0]  o_m_tuser,   // kind
    output logic        o_m_tlast
);
    import cle_pkg::*;

    logic [7:0]  mem [LINE_CAPACITY];
    logic [LINE_CAPACITY-1:0] r_valid;
    logic [AW-1:0] r_pos;

    logic          r_job_v;
    t_op           r_job_op;
    logic [7:0]    r_job_key;
    logic [7:0]    r_job_len;
    logic          r_job_full;
    logic          r_job_bs;
    logic          r_job_oor;
    logic [7:0]    r_rd_data;
    logic          r_rd_valid;
    t_cnt          r_step;

    logic          r_out_v;
    logic [7:0]    r_out_byte;
    logic [7:0]    r_out_len;
    logic [1:0]    r_out_kind;
    logic          r_out_last;

    logic [7:0]    in_key;
    logic [6:0]    in_idx;
    t_op           d_op;
    logic [AW-1:0] d_rd_addr;
    logic          d_oor;
    logic [AW-1:0] pos_m1;
    logic          acc;

    logic [7:0]    rd_byte;
    t_cnt          cnt;
    logic [1:0]    res_kind;
    logic [7:0]    res_byte;
    logic [7:0]    res_len;
    logic          job_last;
    logic          job_emit;
    logic          emit_ok;
    logic          job_done;

    assign in_key = i_s_tdata[7:0];
    assign in_idx = i_s_tdata[14:8];
    assign pos_m1 = r_pos - AW'(1);

    always_comb begin
        if (i_s_tuser == FUNC_READ) begin
            d_op = OP_READ;
        end else begin
            case (in_key)
                KEY_ESC: d_op = OP_ESC;
                KEY_CR:  d_op = OP_CR;
                KEY_BS:  d_op = OP_BS;
                default: d_op = OP_KEY;
            endcase
        end
    end

    assign d_oor     = 32'(in_idx) >= LINE_CAPACITY;
    assign d_rd_addr = (d_op == OP_READ) ? AW'(in_idx) : pos_m1;

    // result sequencing for the item in the job stage
    assign rd_byte = (r_rd_valid && !r_job_oor) ? r_rd_data : 8'h00;

    always_comb begin
        res_kind = KIND_ECHO;
        res_byte = 8'h00;
        res_len  = 8'h00;
        cnt      = t_cnt'(0);
        case (r_job_op)
            OP_READ: begin
                cnt      = t_cnt'(1);
                res_kind = KIND_READ;
                res_byte = rd_byte;
            end
            OP_ESC: begin
                cnt = t_cnt'(3);
                if (r_step == t_cnt'(0)) begin
                    res_byte = KEY_BSLASH;
                end else if (r_step == t_cnt'(1)) begin
                    res_byte = KEY_CR;
                end else begin
                    res_byte = KEY_LF;
                end
            end
            OP_CR: begin
                cnt      = t_cnt'(1);
                res_kind = KIND_DONE;
                res_len  = r_job_len;
            end
            OP_BS: begin
                if (!r_job_bs) begin
                    cnt = t_cnt'(0);
                end else if (rd_byte < KEY_SP) begin
                    cnt = t_cnt'(6);
                end else begin
                    cnt = t_cnt'(3);
                end
                res_byte = (r_step == t_cnt'(1) || r_step == t_cnt'(4)) ? KEY_SP : KEY_BS;
            end
            OP_KEY: begin
                if (r_job_key < KEY_SP) begin
                    cnt = r_job_full ? t_cnt'(3) : t_cnt'(2);
                end else begin
                    cnt = r_job_full ? t_cnt'(2) : t_cnt'(1);
                end
                if (r_job_full && r_step == cnt - t_cnt'(1)) begin
                    res_kind = KIND_DONE;
                    res_len  = 8'(LINE_CAPACITY);
                end else if (r_job_key < KEY_SP) begin
                    res_byte = (r_step == t_cnt'(0)) ? KEY_CARET : r_job_key + CARET_OFS;
                end else begin
                    res_byte = r_job_key;
                end
            end
            default: begin
                cnt = t_cnt'(0);
            end
        endcase
    end

    assign job_last   = r_step == cnt - t_cnt'(1);
    assign job_emit   = r_job_v && cnt != t_cnt'(0);
    assign emit_ok    = !r_out_v || i_m_tready;
    assign job_done   = r_job_v && (cnt == t_cnt'(0) || (emit_ok && job_last));
    assign o_s_tready = !r_job_v || job_done;
    assign acc        = i_s_tvalid && o_s_tready;

    // line store: data array plus per-entry valid flags (invalid reads as zero)
    always_ff @(posedge i_clk) begin
        if (acc && d_op == OP_KEY) begin
            mem[r_pos] <= in_key;
        end
        if (acc) begin
            r_rd_data <= mem[d_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_pos   <= '0;
        end else if (acc) begin
            case (d_op)
                OP_ESC: begin
                    r_valid <= '0;
                    r_pos   <= '0;
                end
                OP_CR: begin
                    r_valid[r_pos] <= 1'b0;
                    r_pos          <= '0;
                end
                OP_BS: begin
                    r_valid[r_pos] <= 1'b0;
                    if (r_pos != '0) begin
                        r_valid[pos_m1] <= 1'b0;
                        r_pos           <= pos_m1;
                    end
                end
                OP_KEY: begin
                    r_valid[r_pos] <= 1'b1;
                    r_pos <= (32'(r_pos) == LINE_CAPACITY - 1) ? '0 : r_pos + AW'(1);
                end
                default: begin
                    r_pos <= r_pos;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_job_op   <= d_op;
            r_job_key  <= in_key;
            r_job_len  <= 8'(r_pos);
            r_job_full <= 32'(r_pos) == LINE_CAPACITY - 1;
            r_job_bs   <= r_pos != '0;
            r_job_oor  <= d_oor;
            r_rd_valid <= r_valid[d_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_v <= 1'b0;
            r_step  <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (acc) begin
                r_job_v <= 1'b1;
            end else if (job_done) begin
                r_job_v <= 1'b0;
            end
            if (job_done) begin
                r_step <= '0;
            end else if (job_emit && emit_ok) begin
                r_step <= r_step + t_cnt'(1);
            end
            if (emit_ok) begin
                r_out_v <= job_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (job_emit && emit_ok) begin
            r_out_kind <= res_kind;
            r_out_byte <= res_byte;
            r_out_len  <= res_len;
            r_out_last <= job_last;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {r_out_len, r_out_byte};
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_kind == KIND_DONE) |-> r_out_last)
        else $error("line done result not marked last");

    a_read_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_kind == KIND_READ) |-> r_out_last)
        else $error("read result not marked last");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_job_v && cnt != t_cnt'(0)) |-> (r_step < cnt))
        else $error("result step past item result count");

    a_esc_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && d_op == OP_ESC) |=> (r_pos == '0 && r_valid == '0))
        else $error("escape did not clear the line");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_job_v && !job_done) |-> !o_s_tready)
        else $error("input taken while item results still pending");

endmodule
